[rtl/irt_pkg.sv]
// Shared types, sizes and codes for the interval reservation table.
`default_nettype none
package irt_pkg;

	localparam int CAPACITY    = 64;
	localparam int TIME_W      = 48;
	localparam int ENTRY_IDX_W = 6;
	localparam int COUNT_OUT_W = 7;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CMP_W       = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_ADD  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_FULL     = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// request broadcast to every cell
	typedef struct packed {
		logic [TIME_W-1:0]      t_start;
		logic [TIME_W-1:0]      t_end;
		logic [ENTRY_IDX_W-1:0] idx;
		logic [CNT_W-1:0]       count;
		logic                   ins_en;
	} bcast_t;

	// what a cell hands to its right-hand neighbor
	typedef struct packed {
		logic [TIME_W-1:0] t_start;
		logic [TIME_W-1:0] t_end;
		logic              gt;
	} link_t;

endpackage
`default_nettype wire

[rtl/interval_reservation_table.sv]
// Top level: request sequencer, output register and the chain of interval cells.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  s_      | in  | start_time[47:0] end_time[47:0] entry_index | req_type
//  m_      | out | read_start[47:0] read_end[47:0] entry_count | status
//
// A request is taken, evaluated by all cells in parallel in S_EVAL, then committed in S_COMMIT;
// a new request can be taken in the same cycle as the previous one commits.
// On commit an insert shifts every larger entry one cell right in the same cycle.
// Reset clears the entry count and control state, not the slot contents; those need no clearing.
// A result waiting in the output register does not block the next request's evaluation;
// only the commit waits for the output register to free up.
`default_nettype none
module interval_reservation_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [103:0]  s_tdata,   // start_time[47:0], end_time[95:48], entry_index[101:96]
	input  logic [1:0]    s_tuser,   // req_type[1:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,   // read_start[47:0], read_end[95:48], entry_count[102:96]
	output logic [1:0]    m_tuser    // status[1:0]
);

	localparam int TW = irt_pkg::TIME_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} state_t;

	state_t                            state_q;
	irt_pkg::req_t                     req_q;
	logic [TW-1:0]                     start_q;
	logic [TW-1:0]                     end_q;
	logic [irt_pkg::ENTRY_IDX_W-1:0]   idx_q;
	logic [irt_pkg::CNT_W-1:0]         count_q;
	logic                              m_tvalid_q;
	irt_pkg::status_t                  status_q;
	logic [TW-1:0]                     rd_start_q;
	logic [TW-1:0]                     rd_end_q;
	logic [irt_pkg::COUNT_OUT_W-1:0]   cnt_out_q;

	irt_pkg::bcast_t                   bc;
	irt_pkg::link_t                    link [irt_pkg::CAPACITY];
	logic [irt_pkg::CAPACITY-1:0]      ovl;
	logic [2*TW-1:0]                   rd   [irt_pkg::CAPACITY];

	logic                              out_free;
	logic                              commit;
	logic                              take;
	logic                              any_ovl;
	logic [2*TW-1:0]                   rd_any;
	logic                              full;
	logic                              ins_ok;
	logic                              out_range;
	irt_pkg::status_t                  status_d;
	logic [irt_pkg::CNT_W-1:0]         count_d;

	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == S_COMMIT) && out_free;
	assign s_tready = (state_q == S_IDLE) || commit;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		any_ovl = |ovl;
		rd_any  = '0;
		for (int i = 0; i < irt_pkg::CAPACITY; i++) begin
			rd_any = rd_any | rd[i];
		end
	end

	assign full      = count_q >= irt_pkg::CNT_W'(irt_pkg::CAPACITY);
	assign out_range = irt_pkg::CMP_W'(idx_q) >= irt_pkg::CMP_W'(count_q);

	always_comb begin
		status_d = irt_pkg::ST_OK;
		ins_ok   = 1'b0;
		unique case (req_q)
			irt_pkg::REQ_LOAD, irt_pkg::REQ_ADD: begin
				if (req_q == irt_pkg::REQ_ADD && any_ovl) begin
					status_d = irt_pkg::ST_CONFLICT;
				end else if (full) begin
					status_d = irt_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			irt_pkg::REQ_READ: begin
				if (out_range) begin
					status_d = irt_pkg::ST_RANGE;
				end
			end
			default: begin
				status_d = irt_pkg::ST_OK;
			end
		endcase
	end

	assign count_d = ins_ok ? count_q + irt_pkg::CNT_W'(1) : count_q;

	assign bc.t_start = start_q;
	assign bc.t_end   = end_q;
	assign bc.idx     = idx_q;
	assign bc.count   = count_q;
	assign bc.ins_en  = commit && ins_ok;

	for (genvar i = 0; i < irt_pkg::CAPACITY; i++) begin : g_cell
		irt_pkg::link_t prev;
		if (i == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = link[i-1];
		end
		irt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.my_idx (irt_pkg::IDX_W'(i)),
			.prev   (prev),
			.link   (link[i]),
			.ovl    (ovl[i]),
			.rd     (rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			req_q      <= irt_pkg::REQ_NONE;
			start_q    <= '0;
			end_q      <= '0;
			idx_q      <= '0;
			status_q   <= irt_pkg::ST_OK;
			rd_start_q <= '0;
			rd_end_q   <= '0;
			cnt_out_q  <= '0;
		end else begin
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (take) begin
				req_q   <= irt_pkg::req_t'(s_tuser);
				start_q <= s_tdata[TW-1:0];
				end_q   <= s_tdata[2*TW-1:TW];
				idx_q   <= s_tdata[2*TW+irt_pkg::ENTRY_IDX_W-1:2*TW];
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						status_q   <= status_d;
						count_q    <= count_d;
						cnt_out_q  <= irt_pkg::COUNT_OUT_W'(count_d);
						if (req_q == irt_pkg::REQ_READ && !out_range) begin
							rd_start_q <= rd_any[TW-1:0];
							rd_end_q   <= rd_any[2*TW-1:TW];
						end else begin
							rd_start_q <= '0;
							rd_end_q   <= '0;
						end
						state_q <= take ? S_EVAL : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, cnt_out_q, rd_end_q, rd_start_q};

	// an insert is only ever committed into a table with room
	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		bc.ins_en |-> (count_q < irt_pkg::CNT_W'(irt_pkg::CAPACITY)))
		else $error("insert committed into a full table");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= irt_pkg::CNT_W'(irt_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		bc.ins_en |=> (count_q == $past(count_q) + irt_pkg::CNT_W'(1)))
		else $error("entry count did not advance on insert");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!bc.ins_en |=> $stable(count_q))
		else $error("entry count changed without an insert");

	a_result_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("commit did not present a result");

endmodule
`default_nettype wire

[rtl/irt_cell.sv]
// One slot of the sorted interval chain: compare flags, read tap and shift-on-insert.
`default_nettype none
module irt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  irt_pkg::bcast_t                bc,
	input  logic [irt_pkg::IDX_W-1:0]      my_idx,
	input  irt_pkg::link_t                 prev,
	output irt_pkg::link_t                 link,
	output logic                           ovl,
	output logic [2*irt_pkg::TIME_W-1:0]   rd
);

	logic [irt_pkg::TIME_W-1:0]   start_q;
	logic [irt_pkg::TIME_W-1:0]   end_q;
	logic                         gt_q;
	logic                         ovl_q;
	logic [2*irt_pkg::TIME_W-1:0] rd_q;
	logic                         valid;
	logic                         at_count;
	logic                         hit;

	assign valid    = irt_pkg::CNT_W'(my_idx) < bc.count;
	assign at_count = irt_pkg::CNT_W'(my_idx) == bc.count;
	assign hit      = irt_pkg::CMP_W'(my_idx) == irt_pkg::CMP_W'(bc.idx);

	// flags are taken every cycle; the commit cycle uses those from the evaluate cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q  <= 1'b0;
			ovl_q <= 1'b0;
		end else begin
			gt_q  <= valid && (start_q > bc.t_start);
			ovl_q <= valid && (bc.t_start < end_q) && (start_q < bc.t_end);
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= (valid && hit) ? {end_q, start_q} : '0;
		if (bc.ins_en) begin
			if (prev.gt) begin
				start_q <= prev.t_start;
				end_q   <= prev.t_end;
			end else if (gt_q || at_count) begin
				start_q <= bc.t_start;
				end_q   <= bc.t_end;
			end
		end
	end

	assign link.t_start = start_q;
	assign link.t_end   = end_q;
	assign link.gt      = gt_q;
	assign ovl          = ovl_q;
	assign rd           = rd_q;

endmodule
`default_nettype wire
